/* rtl/core/pdd_pkg.sv */
// ----------------------------------------------------------------------------
// pdd_pkg
// Types and constants shared by the differential drive PID modules.
// ----------------------------------------------------------------------------
package pdd_pkg;

    localparam int ERR_W    = 16;
    localparam int GAIN_W   = 13;
    localparam int GAIN_I_W = 11;
    localparam int SPEED_W  = 10;
    localparam int LIMIT_W  = 15;
    localparam int DRIVE_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 11'sd1000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -11'sd1000;

    localparam logic [GAIN_W-1:0]   GAIN_P_RST   = 13'd1024;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST   = 13'd1024;
    localparam logic [GAIN_I_W-1:0] GAIN_I_RST   = 11'd0;
    localparam logic [SPEED_W-1:0]  SPEED_RST    = 10'd300;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST    = 15'd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_D      = 3'd1,
        CFG_GAIN_I      = 3'd2,
        CFG_DRIVE_LEVEL = 3'd3,
        CFG_INT_LIMIT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_d;
        logic [GAIN_I_W-1:0] gain_i;
        logic [SPEED_W-1:0]  drive_level;
        logic [LIMIT_W-1:0]  integral_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0] integral;
        logic signed [ERR_W-1:0] prev_error;
    } t_pid_state;

endpackage

/* rtl/core/pid_differential_drive_top.sv */
// ----------------------------------------------------------------------------
// pid_differential_drive_top
// Steering PID for a two-wheel drive with clamped integral and saturated output.
// ----------------------------------------------------------------------------
// One error word is accepted per clock while the input side is not stalled. The
// word lands in an input register, the whole control law (three multiplies, the
// sum, truncation and saturation) is combinational from that register, and its
// drive pair is offered from the result register and held there until taken.
// Throughput is one word per cycle unless the result register stalls; the
// integral and previous error update as the pair enters the result register,
// so consecutive words see each other's state. A stalled result register
// stalls the input side only once both registers are full. Configuration
// writes are always ready and take effect on the next word processed.
module pid_differential_drive_top
    import pdd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [ERR_W-1:0]     i_error,
    input  logic                        i_clear,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DRIVE_W-1:0]   o_left_drive,
    output logic signed [DRIVE_W-1:0]   o_right_drive,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    t_cfg       w_cfg;
    t_pid_state r_state;
    t_pid_state n_state;

    logic                      r_in_valid;
    logic signed [ERR_W-1:0]   r_error;
    logic                      r_clear;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_left;
    logic signed [DRIVE_W-1:0] r_right;
    logic signed [DRIVE_W-1:0] n_left;
    logic signed [DRIVE_W-1:0] n_right;
    logic                      w_adv;

    assign o_cfg_ready = 1'b1;

    pdd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pdd_law u_law (
        .i_cfg         (w_cfg),
        .i_state       (r_state),
        .i_error       (r_error),
        .i_clear       (r_clear),
        .o_state       (n_state),
        .o_left_drive  (n_left),
        .o_right_drive (n_right)
    );

    // Advance the held word into the result register when it has room
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_error <= i_error;
            r_clear <= i_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_clear |=> o_out_valid && o_left_drive == '0 && o_right_drive == '0)
        else $error("clear word did not give zero drive");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_drive <= DRIVE_MAX && o_left_drive >= DRIVE_MIN
                     && o_right_drive <= DRIVE_MAX && o_right_drive >= DRIVE_MIN)
        else $error("drive outside saturation range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_out_valid && !i_out_ready |-> !o_in_ready && !w_adv)
        else $error("pipeline advanced into a stalled result register");

endmodule

/* rtl/core/pdd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pdd_cfg_regs
// Configuration register file: gains, base speed and integral clamp.
// ----------------------------------------------------------------------------
module pdd_cfg_regs
    import pdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:      n_cfg.gain_p         = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:      n_cfg.gain_d         = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:      n_cfg.gain_i         = i_cfg_data[GAIN_I_W-1:0];
                CFG_DRIVE_LEVEL: n_cfg.drive_level    = i_cfg_data[SPEED_W-1:0];
                CFG_INT_LIMIT:   n_cfg.integral_limit = i_cfg_data[LIMIT_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= GAIN_P_RST;
            r_cfg.gain_d         <= GAIN_D_RST;
            r_cfg.gain_i         <= GAIN_I_RST;
            r_cfg.drive_level    <= SPEED_RST;
            r_cfg.integral_limit <= LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/pdd_law.sv */
// ----------------------------------------------------------------------------
// pdd_law
// Control law for one error word: integral clamp, PID sum, drive mixing.
// ----------------------------------------------------------------------------
module pdd_law
    import pdd_pkg::*;
(
    input  t_cfg                       i_cfg,
    input  t_pid_state                 i_state,
    input  logic signed [ERR_W-1:0]    i_error,
    input  logic                       i_clear,
    output t_pid_state                 o_state,
    output logic signed [DRIVE_W-1:0]  o_left_drive,
    output logic signed [DRIVE_W-1:0]  o_right_drive
);

    logic signed [ERR_W:0]   sum;
    logic signed [ERR_W:0]   lim;
    logic signed [ERR_W:0]   sum_clamped;
    logic signed [ERR_W:0]   deriv;
    logic signed [31:0]      prod_p;
    logic signed [31:0]      prod_i;
    logic signed [31:0]      prod_d;
    logic signed [31:0]      acc;
    logic signed [ERR_W-1:0] corr;
    logic signed [17:0]      speed;
    logic signed [17:0]      left_raw;
    logic signed [17:0]      right_raw;
    logic signed [DRIVE_W-1:0] left_sat;
    logic signed [DRIVE_W-1:0] right_sat;

    always_comb begin
        sum = {i_state.integral[ERR_W-1], i_state.integral} + {i_error[ERR_W-1], i_error};
        lim = $signed({2'b00, i_cfg.integral_limit});
        if (sum > lim) begin
            sum_clamped = lim;
        end else if (sum < -lim) begin
            sum_clamped = -lim;
        end else begin
            sum_clamped = sum;
        end
        deriv = {i_error[ERR_W-1], i_error}
              - {i_state.prev_error[ERR_W-1], i_state.prev_error};
    end

    // Use the clamped integral of this tick, not the stored one
    always_comb begin
        prod_p = $signed({1'b0, i_cfg.gain_p}) * i_error;
        prod_i = $signed({1'b0, i_cfg.gain_i}) * sum_clamped;
        prod_d = $signed({1'b0, i_cfg.gain_d}) * deriv;
        acc    = prod_p + prod_i + prod_d;
        // Shift floors; bump negative values with a fraction to truncate toward zero
        corr   = acc[31:16] + ERR_W'(acc[31] && (acc[15:0] != 16'd0));
    end

    always_comb begin
        speed     = $signed({8'd0, i_cfg.drive_level});
        left_raw  = speed - {{2{corr[ERR_W-1]}}, corr};
        right_raw = speed + {{2{corr[ERR_W-1]}}, corr};

        if (left_raw > 18'(DRIVE_MAX)) begin
            left_sat = DRIVE_MAX;
        end else if (left_raw < 18'(DRIVE_MIN)) begin
            left_sat = DRIVE_MIN;
        end else begin
            left_sat = left_raw[DRIVE_W-1:0];
        end

        if (right_raw > 18'(DRIVE_MAX)) begin
            right_sat = DRIVE_MAX;
        end else if (right_raw < 18'(DRIVE_MIN)) begin
            right_sat = DRIVE_MIN;
        end else begin
            right_sat = right_raw[DRIVE_W-1:0];
        end
    end

    always_comb begin
        if (i_clear) begin
            o_state.integral   = '0;
            o_state.prev_error = '0;
            o_left_drive       = '0;
            o_right_drive      = '0;
        end else begin
            o_state.integral   = sum_clamped[ERR_W-1:0];
            o_state.prev_error = i_error;
            o_left_drive       = left_sat;
            o_right_drive      = right_sat;
        end
    end

endmodule

/* tb/tb_pid_differential_drive_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_differential_drive_top
// Self-checking bench for the steering PID. A queue of error words feeds a
// clocked driver. On each accepted word an in-bench copy of the control law
// and its state works out the drive pair. A clocked monitor compares every
// returned pair with the oldest prediction. Both data channels stall at
// random, and the receiver also holds off for long stretches. The registers
// are rewritten between phases, including settings above their normal range.
// ----------------------------------------------------------------------------
module tb_pid_differential_drive_top;
    import pdd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_WORDS = 62;
    localparam int IDLE_PCT    = 12;
    localparam int HOLD_CYCLES = 48;
    localparam int Q16_ONE     = 65536;

    typedef struct packed {
        logic signed [ERR_W-1:0] error;
        logic                    clear;
    } t_tick;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } t_drive_pair;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [ERR_W-1:0]   i_error = '0;
    logic                      i_clear = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [DRIVE_W-1:0] o_left_drive;
    logic signed [DRIVE_W-1:0] o_right_drive;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    t_cfg        model_cfg;
    t_pid_state  model_state;
    t_tick       tick_q[$];
    t_drive_pair drive_expect_q[$];
    t_tick       next_tick;
    t_drive_pair want;
    int          fail_count = 0;
    bit          steady_flow = 1'b0;
    int          hold_left = 0;
    int          hold_gap = 0;
    int          err_bias = 0;

    pid_differential_drive_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_error       (i_error),
        .i_clear       (i_clear),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic signed [DRIVE_W-1:0] clamp_drive(input longint v);
        if (v > DRIVE_MAX) return DRIVE_MAX;
        if (v < DRIVE_MIN) return DRIVE_MIN;
        return v[DRIVE_W-1:0];
    endfunction

    // Advance the controller state by one word and return the drive pair.
    function automatic t_drive_pair next_drive(input t_tick t);
        longint e, integ, lim, acc, corr, spd;
        t_drive_pair r;
        r = '0;
        if (t.clear) begin
            model_state = '0;
            return r;
        end
        e     = longint'($signed(t.error));
        lim   = longint'(model_cfg.integral_limit);
        integ = longint'($signed(model_state.integral)) + e;
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;
        acc = longint'(model_cfg.gain_p) * e
            + longint'(model_cfg.gain_i) * integ
            + longint'(model_cfg.gain_d) * (e - longint'($signed(model_state.prev_error)));
        model_state.integral   = integ[ERR_W-1:0];
        model_state.prev_error = t.error;
        // signed division truncates toward zero
        corr    = acc / Q16_ONE;
        spd     = longint'(model_cfg.drive_level);
        r.left  = clamp_drive(spd - corr);
        r.right = clamp_drive(spd + corr);
        return r;
    endfunction

    function automatic int cfg_value(input int lo, input int hi);
        // now and then a raw value over the whole data width
        if ($urandom_range(4) == 0) return $urandom_range(2**CFG_DATA_W - 1);
        return $urandom_range(hi, lo);
    endfunction

    function automatic t_tick random_tick();
        t_tick t;
        int pick;
        pick    = $urandom_range(99);
        t.clear = (pick < 4);
        if (pick < 60) begin
            t.error = ERR_W'(err_bias + int'($urandom_range(1023)) - 512);
        end else if (pick < 85) begin
            t.error = ERR_W'(int'($urandom_range(8191)) - 4096);
        end else begin
            t.error = ERR_W'($urandom);
        end
        return t;
    endfunction

    task automatic push_tick(input logic signed [ERR_W-1:0] err, input logic clr);
        tick_q.push_back(t_tick'{err, clr});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_P:      model_cfg.gain_p = data[GAIN_W-1:0];
            CFG_GAIN_D:      model_cfg.gain_d = data[GAIN_W-1:0];
            CFG_GAIN_I:      model_cfg.gain_i = data[GAIN_I_W-1:0];
            CFG_DRIVE_LEVEL: model_cfg.drive_level = data[SPEED_W-1:0];
            CFG_INT_LIMIT:   model_cfg.integral_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int kp, input int kd, input int ki, input int spd,
                             input int lim);
        write_reg(CFG_GAIN_P, CFG_DATA_W'(kp));
        write_reg(CFG_GAIN_D, CFG_DATA_W'(kd));
        write_reg(CFG_GAIN_I, CFG_DATA_W'(ki));
        write_reg(CFG_DRIVE_LEVEL, CFG_DATA_W'(spd));
        write_reg(CFG_INT_LIMIT, CFG_DATA_W'(lim));
    endtask

    // Hold until every queued word has gone in and every drive pair is back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || i_in_valid || drive_expect_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Sender: present the next queued word once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                drive_expect_q.push_back(next_drive(t_tick'{i_error, i_clear}));
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                    next_tick = tick_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_error    <= next_tick.error;
                    i_clear    <= next_tick.clear;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs, so the pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_gap  <= 60;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_gap != 0) begin
            hold_gap <= hold_gap - 1;
        end else if (!steady_flow) begin
            hold_left <= HOLD_CYCLES;
            hold_gap  <= 150 + $urandom_range(150);
        end
    end

    // Receiver: check each drive pair against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (drive_expect_q.size() == 0) begin
                    $error("drive word with none pending: left %0d right %0d",
                           o_left_drive, o_right_drive);
                    fail_count++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (o_left_drive !== want.left) begin
                        $error("left_drive: expected %0d, got %0d", want.left, o_left_drive);
                        fail_count++;
                    end
                    if (o_right_drive !== want.right) begin
                        $error("right_drive: expected %0d, got %0d", want.right,
                               o_right_drive);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && (steady_flow || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        #200000;
        $display("tb_pid_differential_drive_top: FAIL");
        $finish;
    end

    initial begin
        model_cfg   = '{GAIN_P_RST, GAIN_D_RST, GAIN_I_RST, SPEED_RST, LIMIT_RST};
        model_state = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains: error extremes, a repeated step, clear with a live error
        push_tick(16'sd0, 1'b0);
        push_tick(16'sd32767, 1'b0);
        push_tick(-16'sd32768, 1'b0);
        push_tick(-16'sd32768, 1'b0);
        push_tick(16'sd256, 1'b0);
        push_tick(16'sd256, 1'b0);
        push_tick(16'sd1234, 1'b1);
        push_tick(16'sd1, 1'b0);
        push_tick(-16'sd1, 1'b0);
        wait_idle();

        // top of the normal ranges: integral runs into both clamps
        write_all(5120, 5120, 1280, 800, 32767);
        repeat (3) push_tick(16'sd32767, 1'b0);
        repeat (3) push_tick(-16'sd32768, 1'b0);
        push_tick(-16'sd1, 1'b1);
        push_tick(-16'sd1, 1'b0);
        wait_idle();

        // all-ones data above each register's range, zero integral limit
        write_all(2**CFG_DATA_W - 1, 2**CFG_DATA_W - 1, 2**CFG_DATA_W - 1,
                  2**CFG_DATA_W - 1, 0);
        for (int k = CFG_IDX_SPARE; k < 2**CFG_IDX_W; k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        push_tick(16'sd32767, 1'b0);
        push_tick(-16'sd32768, 1'b0);
        push_tick(16'sd100, 1'b0);
        push_tick(16'sd0, 1'b0);
        wait_idle();

        // bottom of the ranges: no correction at all, minimum speed
        write_all(0, 0, 0, 50, 1);
        push_tick(-16'sd32768, 1'b0);
        push_tick(16'sd32767, 1'b0);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_all(cfg_value(0, 5120), cfg_value(0, 5120), cfg_value(0, 1280),
                      cfg_value(50, 800), cfg_value(0, 4096));
            @(negedge i_clk);
            err_bias    = int'($urandom_range(600)) - 300;
            steady_flow = (ph == 1);
            repeat (PHASE_WORDS) tick_q.push_back(random_tick());
            wait_idle();
        end
        steady_flow = 1'b0;

        repeat (8) @(posedge i_clk);
        if (drive_expect_q.size() != 0) begin
            $error("%0d drive words never returned", drive_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb_pid_differential_drive_top: PASS");
        end else begin
            $display("tb_pid_differential_drive_top: FAIL");
        end
        $finish;
    end

endmodule
